### src/clcs_pkg.sv
// Shared types, codes, constants and init tables for the character LCD command sequencer.
package clcs_pkg;

    localparam int LINE_COUNT_DEF = 4;
    localparam int LINE_MAX       = 4;

    localparam int ACTION_W   = 3;
    localparam int LINE_W     = 2;
    localparam int COLUMN_W   = 6;
    localparam int BYTE_W     = 8;
    localparam int BASE_W     = 7;
    localparam int SETTLE_W   = 16;
    localparam int WAIT_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int INIT_BYTES = 8;
    localparam int INIT_IDX_W = 3;

    // Command codes of the input beat.
    localparam logic [ACTION_W-1:0] ACT_INIT     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CURSOR   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUT_CHAR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DISP_ON  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DISP_OFF = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE0_BASE    = 3'd1;

    // Controller command bytes.
    localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME    = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_ENTRY   = 8'h04;
    localparam logic [BYTE_W-1:0] ENTRY_INC   = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_DISPCTL = 8'h08;
    localparam logic [BYTE_W-1:0] DISP_ON     = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_FUNCSET = 8'h20;
    localparam logic [BYTE_W-1:0] FS_8BIT     = 8'h10;
    localparam logic [BYTE_W-1:0] FS_2LINES   = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_ADDR    = 8'h80;

    // Reset values of the line base registers.
    localparam logic [BASE_W-1:0] LINE_BASE_RESET [LINE_MAX] = '{7'd0, 7'd64, 7'd20, 7'd84};

    // Timing in microseconds.
    localparam logic [SETTLE_W-1:0] POWER_SETTLE_US = 16'd50000;
    localparam logic [WAIT_W-1:0]   STROBE_HIGH_US  = 13'd10;
    localparam logic [WAIT_W-1:0]   BYTE_DONE_US    = 13'd50;

    // Extra delay after the final write of a byte.
    localparam logic [1:0] EXTRA_NONE = 2'd0;
    localparam logic [1:0] EXTRA_200  = 2'd1;
    localparam logic [1:0] EXTRA_5000 = 2'd2;
    localparam logic [1:0] EXTRA_2000 = 2'd3;

    typedef struct packed {
        logic              is_init;
        logic              four_bit;
        logic [BYTE_W-1:0] data;
        logic              rs;
        logic [1:0]        extra;
    } cmd_desc_t;

    function automatic logic [WAIT_W-1:0] byte_done_wait(input logic [1:0] extra);
        logic [WAIT_W-1:0] w;
        case (extra)
            EXTRA_200:  w = BYTE_DONE_US + 13'd200;
            EXTRA_5000: w = BYTE_DONE_US + 13'd5000;
            EXTRA_2000: w = BYTE_DONE_US + 13'd2000;
            default:    w = BYTE_DONE_US;
        endcase
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_IDX_W-1:0] idx,
                                                    input logic four_bit);
        logic [BYTE_W-1:0] mode_bit;
        logic [BYTE_W-1:0] b;
        mode_bit = four_bit ? 8'h00 : FS_8BIT;
        case (idx)
            3'd0:    b = CMD_FUNCSET | FS_8BIT;
            3'd1:    b = CMD_FUNCSET | FS_8BIT;
            3'd2:    b = CMD_FUNCSET | mode_bit;
            3'd3:    b = CMD_FUNCSET | mode_bit | FS_2LINES;
            3'd4:    b = CMD_DISPCTL | DISP_ON;
            3'd5:    b = CMD_ENTRY | ENTRY_INC;
            3'd6:    b = CMD_CLEAR;
            default: b = CMD_HOME;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] init_extra(input logic [INIT_IDX_W-1:0] idx);
        logic [1:0] e;
        case (idx)
            3'd0:    e = EXTRA_5000;
            3'd1:    e = EXTRA_200;
            3'd6:    e = EXTRA_2000;
            3'd7:    e = EXTRA_2000;
            default: e = EXTRA_NONE;
        endcase
        return e;
    endfunction

endpackage

### src/clcs_front.sv
// Front end: configuration registers, command decode and display state.
module clcs_front #(
    parameter int LINE_COUNT = clcs_pkg::LINE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [clcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  logic [clcs_pkg::ACTION_W-1:0]       action,
    input  logic [clcs_pkg::LINE_W-1:0]         line,
    input  logic [clcs_pkg::COLUMN_W-1:0]       column,
    input  logic [clcs_pkg::BYTE_W-1:0]         char_code,
    output logic                                desc_valid,
    output clcs_pkg::cmd_desc_t                 desc
);
    import clcs_pkg::*;

    localparam int LINE_IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

    logic              four_bit_reg;
    logic [BASE_W-1:0] line_base_reg [LINE_COUNT];
    logic              display_on_reg;
    logic              display_on_next;
    logic              line_ok;
    logic [BASE_W-1:0] base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b1;
        end
        else if (cfg_write && cfg_index == REG_FOUR_BIT_MODE)
        begin
            four_bit_reg <= cfg_data[0];
        end
    end

    for (genvar i = 0; i < LINE_COUNT; i++)
    begin : g_base
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                line_base_reg[i] <= LINE_BASE_RESET[i];
            end
            else if (cfg_write && cfg_index == REG_LINE0_BASE + CFG_IDX_W'(i))
            begin
                line_base_reg[i] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_on_reg <= 1'b0;
        end
        else if (accept)
        begin
            display_on_reg <= display_on_next;
        end
    end

    assign line_ok = {1'b0, line} < 3'(LINE_COUNT);
    assign base    = line_ok ? line_base_reg[line[LINE_IDX_W-1:0]] : '0;

    always_comb
    begin
        display_on_next = display_on_reg;
        desc_valid      = 1'b0;
        desc.is_init    = 1'b0;
        desc.four_bit   = four_bit_reg;
        desc.data       = '0;
        desc.rs         = 1'b0;
        desc.extra      = EXTRA_NONE;
        case (action)
            ACT_INIT:
            begin
                display_on_next = 1'b1;
                desc_valid      = accept;
                desc.is_init    = 1'b1;
            end
            ACT_CLEAR:
            begin
                desc_valid = accept;
                desc.data  = CMD_CLEAR;
                desc.extra = EXTRA_2000;
            end
            ACT_CURSOR:
            begin
                desc_valid = accept && line_ok;
                desc.data  = CMD_ADDR | {1'b0, base | {1'b0, column}};
            end
            ACT_PUT_CHAR:
            begin
                desc_valid = accept;
                desc.data  = char_code;
                desc.rs    = 1'b1;
            end
            ACT_DISP_ON:
            begin
                display_on_next = 1'b1;
                desc_valid      = accept;
                desc.data       = CMD_DISPCTL | (display_on_next ? DISP_ON : 8'h00);
            end
            ACT_DISP_OFF:
            begin
                display_on_next = 1'b0;
                desc_valid      = accept;
                desc.data       = CMD_DISPCTL | (display_on_next ? DISP_ON : 8'h00);
            end
            default:
            begin
                desc_valid = 1'b0;
            end
        endcase
    end

endmodule

### src/clcs_queue.sv
// Two-entry queue of decoded commands between the front and back ends.
module clcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  clcs_pkg::cmd_desc_t wr_desc,
    output logic                is_full,
    input  logic                rd_en,
    output logic                rd_valid,
    output clcs_pkg::cmd_desc_t rd_desc
);
    import clcs_pkg::*;

    cmd_desc_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign is_full  = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_desc  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

### src/clcs_back.sv
// Back end: expands one decoded command into bus writes, one per cycle while the output is not held.
module clcs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              desc_valid,
    input  clcs_pkg::cmd_desc_t               desc,
    output logic                              desc_done,
    output logic                              empty,
    input  logic                              pop,
    output logic [clcs_pkg::BYTE_W-1:0]       bus_data,
    output logic                              reg_select,
    output logic                              enable,
    output logic [clcs_pkg::SETTLE_W-1:0]     settle_before_us,
    output logic [clcs_pkg::WAIT_W-1:0]       wait_after_us,
    output logic                              last
);
    import clcs_pkg::*;

    logic [INIT_IDX_W-1:0] byte_idx_reg;
    logic [1:0]            beat_idx_reg;
    logic                  out_valid_reg;

    logic [BYTE_W-1:0]   data_reg;
    logic                rs_reg;
    logic                en_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [WAIT_W-1:0]   wait_reg;
    logic                last_reg;

    logic                step;
    logic [BYTE_W-1:0]   cur_byte;
    logic [1:0]          cur_extra;
    logic                byte_end;
    logic                cmd_end;
    logic                en_now;
    logic [BYTE_W-1:0]   data_now;
    logic [WAIT_W-1:0]   wait_now;
    logic [SETTLE_W-1:0] settle_now;

    assign step      = desc_valid && (!out_valid_reg || pop);
    assign cur_byte  = desc.is_init ? init_byte(byte_idx_reg, desc.four_bit) : desc.data;
    assign cur_extra = desc.is_init ? init_extra(byte_idx_reg) : desc.extra;
    assign byte_end  = desc.four_bit ? (beat_idx_reg == 2'd3) : (beat_idx_reg == 2'd1);
    assign cmd_end   = byte_end && (!desc.is_init || byte_idx_reg == INIT_IDX_W'(INIT_BYTES - 1));
    assign en_now    = ~beat_idx_reg[0];

    // In 4-bit mode the first strobe pair carries the high nibble.
    assign data_now = !desc.four_bit ? cur_byte
                    : (beat_idx_reg[1] ? {4'h0, cur_byte[3:0]} : {4'h0, cur_byte[7:4]});
    assign wait_now = en_now ? STROBE_HIGH_US
                    : (byte_end ? byte_done_wait(cur_extra) : '0);
    assign settle_now = (desc.is_init && byte_idx_reg == '0 && beat_idx_reg == 2'd0)
                      ? POWER_SETTLE_US : '0;

    assign desc_done = step && cmd_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg  <= '0;
            beat_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                if (cmd_end)
                begin
                    byte_idx_reg <= '0;
                    beat_idx_reg <= 2'd0;
                end
                else if (byte_end)
                begin
                    byte_idx_reg <= byte_idx_reg + INIT_IDX_W'(1);
                    beat_idx_reg <= 2'd0;
                end
                else
                begin
                    beat_idx_reg <= beat_idx_reg + 2'd1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg   <= data_now;
            rs_reg     <= desc.rs;
            en_reg     <= en_now;
            settle_reg <= settle_now;
            wait_reg   <= wait_now;
            last_reg   <= cmd_end;
        end
    end

    assign empty            = !out_valid_reg;
    assign bus_data         = data_reg;
    assign reg_select       = rs_reg;
    assign enable           = en_reg;
    assign settle_before_us = settle_reg;
    assign wait_after_us    = wait_reg;
    assign last             = last_reg;

endmodule

### src/character_lcd_command_sequencer_unit.sv
// Top level of the character LCD command sequencer: front end, command queue, back end.
//
//  Channel    Direction  Handshake               Beat contents
//  command    in         push / full             action, line, column, char_code
//  bus write  out        pop / empty             bus_data, reg_select, enable,
//                                                settle_before_us, wait_after_us, last
//  config     in         cfg_write               cfg_index, cfg_data
//
// The back end issues one bus write per cycle while the output is not held: a command is
// 2 writes (8-bit) or 4 writes (4-bit), and init is 16 or 32, set by the write sequencer's counters.
// The front end takes one command per cycle while the two-entry queue has room;
// commands that cause no writes are taken and dropped there.
// Reset restores the register defaults and empties the queue and output stage.
// A held output beat stalls the sequencer, which in turn fills the queue and raises full.
module character_lcd_command_sequencer_unit #(
    parameter int LINE_COUNT = clcs_pkg::LINE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [clcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [clcs_pkg::ACTION_W-1:0]     action,
    input  logic [clcs_pkg::LINE_W-1:0]       line,
    input  logic [clcs_pkg::COLUMN_W-1:0]     column,
    input  logic [clcs_pkg::BYTE_W-1:0]       char_code,
    output logic                              empty,
    input  logic                              pop,
    output logic [clcs_pkg::BYTE_W-1:0]       bus_data,
    output logic                              reg_select,
    output logic                              enable,
    output logic [clcs_pkg::SETTLE_W-1:0]     settle_before_us,
    output logic [clcs_pkg::WAIT_W-1:0]       wait_after_us,
    output logic                              last
);
    import clcs_pkg::*;

    logic      accept;
    logic      front_valid;
    cmd_desc_t front_desc;
    logic      q_valid;
    cmd_desc_t q_desc;
    logic      q_pop;

    assign accept = push && !full;

    clcs_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .action     (action),
        .line       (line),
        .column     (column),
        .char_code  (char_code),
        .desc_valid (front_valid),
        .desc       (front_desc)
    );

    clcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_desc  (front_desc),
        .is_full  (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_desc  (q_desc)
    );

    clcs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .desc_valid       (q_valid),
        .desc             (q_desc),
        .desc_done        (q_pop),
        .empty            (empty),
        .pop              (pop),
        .bus_data         (bus_data),
        .reg_select       (reg_select),
        .enable           (enable),
        .settle_before_us (settle_before_us),
        .wait_after_us    (wait_after_us),
        .last             (last)
    );

endmodule
